// File: rtl/core/smq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smq_pkg: shared types and constants of the six-axis motion qualifier
// Beat layouts, register indexes, event codes, and the command and status
// bundles between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package smq_pkg;

  // Field and state widths
  localparam int AXES       = 6;
  localparam int AXIS_IDX_W = 3;
  localparam int AXIS_W     = 16;
  localparam int THR_W      = 15;
  localparam int CNT_W      = 16;
  localparam int MS_W       = 16;
  localparam int SUM_W      = 17;
  localparam int DVD_W      = SUM_W + 1;   // sum plus period before the wrap
  localparam int EV_W       = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL    = 2'd2;

  localparam logic [THR_W-1:0] RESET_THRESHOLD   = 15'd256;
  localparam logic [CNT_W-1:0] RESET_EVENT_COUNT = 16'd16;
  localparam logic [MS_W-1:0]  RESET_INTERVAL    = 16'd0;

  // Event codes
  localparam logic [EV_W-1:0] EV_NONE = 2'd0;
  localparam logic [EV_W-1:0] EV_POS  = 2'd1;
  localparam logic [EV_W-1:0] EV_NEG  = 2'd2;

  localparam logic [AXIS_IDX_W-1:0] LAST_AXIS = 3'(AXES - 1);

  typedef struct packed {
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
    logic signed [AXIS_W-1:0] axis_rx;
    logic signed [AXIS_W-1:0] axis_ry;
    logic signed [AXIS_W-1:0] axis_rz;
    logic        [MS_W-1:0]   period_ms;
  } smq_in_t;

  typedef struct packed {
    logic [EV_W-1:0] event_x;
    logic [EV_W-1:0] event_y;
    logic [EV_W-1:0] event_z;
    logic [EV_W-1:0] event_rx;
    logic [EV_W-1:0] event_ry;
    logic [EV_W-1:0] event_rz;
  } smq_out_t;

  // Sequencer to datapath
  typedef struct packed {
    logic                  capture;
    logic                  eval;
    logic                  div_store;
    logic                  out_load;
    logic [AXIS_IDX_W-1:0] axis;
  } smq_cmd_t;

  // Datapath to sequencer
  typedef struct packed {
    logic need_div;
    logic rem_done;
    logic out_free;
  } smq_sts_t;

endpackage

// File: rtl/core/smq_rem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smq_rem: bit-serial remainder unit
// Restoring division, one dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module smq_rem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [smq_pkg::DVD_W-1:0] dividend,
  input  logic [smq_pkg::MS_W-1:0]  divisor,
  output logic                      done,
  output logic [smq_pkg::MS_W-1:0]  remainder
);
  import smq_pkg::*;

  localparam int STEPS  = DVD_W;
  localparam int STEP_W = $clog2(STEPS);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [MS_W-1:0]   dvs_r;
  logic [MS_W-1:0]   rem_r;

  logic [MS_W:0]     trial;
  logic              fits;
  logic [MS_W:0]     diff;
  logic [MS_W-1:0]   rem_nxt;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial   = {rem_r, dvd_r[DVD_W-1]};
    fits    = trial >= {1'b0, dvs_r};
    diff    = trial - {1'b0, dvs_r};
    rem_nxt = fits ? diff[MS_W-1:0] : trial[MS_W-1:0];
  end

  // Control: busy while the dividend bits are stepped through, then a one-cycle done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operands and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// File: rtl/core/smq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smq_dp: motion qualifier datapath
// Config registers, captured sample, per-axis run counters and time sums,
// the shared remainder unit and the result register.
// ----------------------------------------------------------------------------
module smq_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [smq_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [smq_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  smq_pkg::smq_in_t               in_data,
  input  smq_pkg::smq_cmd_t              cmd,
  output smq_pkg::smq_sts_t              sts,
  output logic                           out_valid,
  input  logic                           out_stall,
  output smq_pkg::smq_out_t              out_data
);
  import smq_pkg::*;

  logic [THR_W-1:0] thr_r;
  logic [CNT_W-1:0] evcnt_r;
  logic [MS_W-1:0]  intv_r;

  logic signed [AXIS_W-1:0] axis_r [AXES];
  logic [MS_W-1:0]          period_r;

  logic [CNT_W-1:0] pos_cnt_r [AXES];
  logic [CNT_W-1:0] neg_cnt_r [AXES];
  logic [SUM_W-1:0] pos_sum_r [AXES];
  logic [SUM_W-1:0] neg_sum_r [AXES];
  logic [EV_W-1:0]  ev_r      [AXES];
  logic [EV_W-1:0]  dir_r;

  smq_out_t out_r;
  logic     out_vld_r;

  // Axis evaluation
  logic signed [AXIS_W:0] v_ext;
  logic signed [AXIS_W:0] t_ext;
  logic                   is_pos;
  logic                   is_neg;
  logic                   time_mode;
  logic [CNT_W-1:0]       cur_cnt;
  logic [SUM_W-1:0]       cur_sum;
  logic [CNT_W:0]         cnt_inc;
  logic                   cnt_fire;
  logic [CNT_W-1:0]       cnt_nxt;
  logic [DVD_W-1:0]       time_s;
  logic                   time_fire;
  logic [EV_W-1:0]        code;
  logic                   rem_start;
  logic                   rem_done;
  logic [MS_W-1:0]        rem_val;

  // Dead-band compare, then count or time step for the current axis
  always_comb begin
    v_ext     = {axis_r[cmd.axis][AXIS_W-1], axis_r[cmd.axis]};
    t_ext     = $signed({{(AXIS_W + 1 - THR_W){1'b0}}, thr_r});
    is_pos    = v_ext > t_ext;
    is_neg    = v_ext < -t_ext;
    time_mode = intv_r != '0;
    code      = is_pos ? EV_POS : EV_NEG;
    cur_cnt   = is_pos ? pos_cnt_r[cmd.axis] : neg_cnt_r[cmd.axis];
    cur_sum   = is_pos ? pos_sum_r[cmd.axis] : neg_sum_r[cmd.axis];
    cnt_inc   = {1'b0, cur_cnt} + 1'b1;
    cnt_fire  = cnt_inc >= {1'b0, evcnt_r};
    cnt_nxt   = cnt_fire ? '0 : cnt_inc[CNT_W-1:0];
    time_s    = {1'b0, cur_sum} + {{(DVD_W - MS_W){1'b0}}, period_r};
    time_fire = time_s > {{(DVD_W - MS_W){1'b0}}, intv_r};
    rem_start = cmd.eval && (is_pos || is_neg) && time_mode && time_fire;
  end

  smq_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (time_s),
    .divisor   (intv_r),
    .done      (rem_done),
    .remainder (rem_val)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= RESET_THRESHOLD;
      evcnt_r <= RESET_EVENT_COUNT;
      intv_r  <= RESET_INTERVAL;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_THRESHOLD:   thr_r   <= cfg_wdata[THR_W-1:0];
        CFG_EVENT_COUNT: evcnt_r <= cfg_wdata[CNT_W-1:0];
        CFG_INTERVAL:    intv_r  <= cfg_wdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample capture on the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      axis_r[0] <= in_data.axis_x;
      axis_r[1] <= in_data.axis_y;
      axis_r[2] <= in_data.axis_z;
      axis_r[3] <= in_data.axis_rx;
      axis_r[4] <= in_data.axis_ry;
      axis_r[5] <= in_data.axis_rz;
      period_r  <= in_data.period_ms;
    end
  end

  // Per-axis counters and time sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        pos_cnt_r[i] <= '0;
        neg_cnt_r[i] <= '0;
        pos_sum_r[i] <= '0;
        neg_sum_r[i] <= '0;
      end
    end else if (cmd.eval) begin
      if (!is_pos && !is_neg) begin
        pos_cnt_r[cmd.axis] <= '0;
        neg_cnt_r[cmd.axis] <= '0;
        pos_sum_r[cmd.axis] <= '0;
        neg_sum_r[cmd.axis] <= '0;
      end else if (!time_mode) begin
        if (is_pos) begin
          pos_cnt_r[cmd.axis] <= cnt_nxt;
          neg_cnt_r[cmd.axis] <= '0;
        end else begin
          neg_cnt_r[cmd.axis] <= cnt_nxt;
          pos_cnt_r[cmd.axis] <= '0;
        end
      end else if (!time_fire) begin
        if (is_pos) pos_sum_r[cmd.axis] <= time_s[SUM_W-1:0];
        else        neg_sum_r[cmd.axis] <= time_s[SUM_W-1:0];
      end
    end else if (cmd.div_store) begin
      if (dir_r == EV_POS) pos_sum_r[cmd.axis] <= {1'b0, rem_val};
      else                 neg_sum_r[cmd.axis] <= {1'b0, rem_val};
    end
  end

  // Working event codes; direction held across the remainder wait
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      dir_r <= code;
      if (!is_pos && !is_neg)
        ev_r[cmd.axis] <= EV_NONE;
      else if (!time_mode)
        ev_r[cmd.axis] <= cnt_fire ? code : EV_NONE;
      else
        ev_r[cmd.axis] <= EV_NONE;
    end else if (cmd.div_store) begin
      ev_r[cmd.axis] <= dir_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.event_x  <= ev_r[0];
      out_r.event_y  <= ev_r[1];
      out_r.event_z  <= ev_r[2];
      out_r.event_rx <= ev_r[3];
      out_r.event_ry <= ev_r[4];
      out_r.event_rz <= ev_r[5];
    end
  end

  assign sts.need_div = rem_start;
  assign sts.rem_done = rem_done;
  assign sts.out_free = !out_vld_r || !out_stall;
  assign out_valid    = out_vld_r;
  assign out_data     = out_r;

endmodule

// File: rtl/core/smq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smq_ctrl: motion qualifier sequencer
// Walks the six axes of a captured sample, waits on the remainder unit when
// a time-mode event wraps, then hands the result to the output register.
// ----------------------------------------------------------------------------
module smq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  smq_pkg::smq_sts_t  sts,
  output smq_pkg::smq_cmd_t  cmd
);
  import smq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]            state_r;
  logic [1:0]            state_nxt;
  logic [AXIS_IDX_W-1:0] axis_r;
  logic [AXIS_IDX_W-1:0] axis_nxt;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    cmd.capture   = 1'b0;
    cmd.eval      = 1'b0;
    cmd.div_store = 1'b0;
    cmd.out_load  = 1'b0;
    cmd.axis      = axis_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          axis_nxt    = '0;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.need_div) begin
          state_nxt = ST_DIV;
        end else if (axis_r == LAST_AXIS) begin
          state_nxt = ST_OUT;
        end else begin
          axis_nxt = axis_r + 1'b1;
        end
      end
      ST_DIV: begin
        if (sts.rem_done) begin
          cmd.div_store = 1'b1;
          if (axis_r == LAST_AXIS) begin
            state_nxt = ST_OUT;
          end else begin
            axis_nxt  = axis_r + 1'b1;
            state_nxt = ST_EVAL;
          end
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  assign in_stall = state_r != ST_IDLE;

endmodule

// File: rtl/core/six_axis_motion_qualifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// six_axis_motion_qualifier_top: six-axis motion sample qualifier
// Per axis dead-band check, then count-mode or time-mode event generation.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------
//   in      | input     | in_valid/in_stall  | in_data  (smq_in_t)
//   out     | output    | out_valid/out_stall| out_data (smq_out_t)
//   cfg     | input     | cfg_we             | cfg_idx, cfg_wdata
//
// Each axis whose time sum wraps waits in the shared bit-serial remainder
// unit (one dividend bit per cycle) before the next axis is evaluated.
// Reset is synchronous; it restores register defaults and clears all
// counters and sums. The result register holds one beat, so a new sample is
// accepted while a result is stalled; out_stall holds the sequencer only
// when the next result is ready and the register is still full.
// ----------------------------------------------------------------------------
module six_axis_motion_qualifier_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [smq_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [smq_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  smq_pkg::smq_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output smq_pkg::smq_out_t              out_data
);
  import smq_pkg::*;

  smq_cmd_t cmd;
  smq_sts_t sts;

  smq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  smq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
